// File: src/mtvb_pkg.sv
package mtvb_pkg;

    localparam int NUM_VERTICES = 1024;
    localparam int NUM_TARGETS  = 16;
    localparam int WEIGHT_FRAC  = 12;

    localparam int VTX_AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int TGT_AW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_SET     = 3'd1,
        ACT_RESTORE = 3'd2,
        ACT_ADVANCE = 3'd3,
        ACT_APPLY   = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    typedef struct packed {
        logic        [2:0]  action;
        logic        [3:0]  target_index;
        logic        [9:0]  vertex_index;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
        logic signed [15:0] weight_goal;
        logic        [14:0] weight_step;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic signed [15:0] weight_now;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vertex_t;

endpackage

// File: src/morph_target_vertex_blend.sv
// The input item is registered in the execute stage and its result in the output
// register behind m_valid. Throughput: one item per cycle unless m_ready stalls;
// the base and working vertex memories are read on the transfer edge and written
// back as the item leaves the execute stage, with bypass on a hit.
// Stalls: m_ready low holds the result; s_ready drops only when both stages are full.
// Reset (aresetn, synchronous, active low) clears the pipeline valids and all
// target ramps; vertex memories are not cleared and hold no data until loaded.
module morph_target_vertex_blend (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtvb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mtvb_pkg::out_item_t m_data
);

    // Vertex memories: one write and one registered read port each.
    mtvb_pkg::vertex_t base_mem [mtvb_pkg::NUM_VERTICES];
    mtvb_pkg::vertex_t work_mem [mtvb_pkg::NUM_VERTICES];
    mtvb_pkg::vertex_t base_rd_reg;
    mtvb_pkg::vertex_t work_rd_reg;

    // Per-target weight ramps (small, reset to zero).
    logic signed [15:0] ramp_cur_reg  [mtvb_pkg::NUM_TARGETS];
    logic signed [15:0] ramp_goal_reg [mtvb_pkg::NUM_TARGETS];
    logic        [14:0] ramp_step_reg [mtvb_pkg::NUM_TARGETS];

    // Execute stage
    logic                s1_valid_reg;
    mtvb_pkg::in_item_t  s1_item_reg;

    // Bypass: data written in the same cycle the memory was read
    logic                fwd_base_hit_reg;
    logic                fwd_work_hit_reg;
    logic                fwd_base_hit_next;
    logic                fwd_work_hit_next;
    mtvb_pkg::vertex_t   fwd_base_reg;
    mtvb_pkg::vertex_t   fwd_work_reg;

    logic                m_valid_reg;
    mtvb_pkg::out_item_t m_data_reg;

    logic                    adv;
    logic                    accept;
    logic                    s1_fire;
    logic [mtvb_pkg::VTX_AW-1:0] rd_addr;
    logic [mtvb_pkg::VTX_AW-1:0] s1_vaddr;
    logic [mtvb_pkg::TGT_AW-1:0] s1_taddr;
    logic                    vok;
    logic                    tok;
    mtvb_pkg::vertex_t       base_cur;
    mtvb_pkg::vertex_t       work_cur;
    mtvb_pkg::vertex_t       offset;
    mtvb_pkg::vertex_t       applied;
    mtvb_pkg::vertex_t       work_new;
    mtvb_pkg::vertex_t       base_new;
    logic                    work_we;
    logic                    base_we;
    logic signed [15:0]      weight;
    logic signed [15:0]      goal;
    logic        [14:0]      step;
    logic signed [16:0]      cur_dec;
    logic signed [16:0]      cur_inc;
    logic signed [15:0]      cur_new;
    logic                    cur_we;
    logic                    ramp_set;
    logic signed [31:0]      prod_x;
    logic signed [31:0]      prod_y;
    logic signed [31:0]      prod_z;
    mtvb_pkg::out_item_t     result;

    // Output register empty or draining: execute stage may complete.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || adv;
    assign accept  = s_valid && s_ready;
    assign s1_fire = s1_valid_reg && adv;

    assign rd_addr  = mtvb_pkg::VTX_AW'(s_data.vertex_index);
    assign s1_vaddr = mtvb_pkg::VTX_AW'(s1_item_reg.vertex_index);
    assign s1_taddr = mtvb_pkg::TGT_AW'(s1_item_reg.target_index);

    assign vok = 32'(s1_item_reg.vertex_index) < mtvb_pkg::NUM_VERTICES;
    assign tok = 32'(s1_item_reg.target_index) < mtvb_pkg::NUM_TARGETS;

    // Read side: bypass covers the write that landed on the read edge.
    assign base_cur = fwd_base_hit_reg ? fwd_base_reg : base_rd_reg;
    assign work_cur = fwd_work_hit_reg ? fwd_work_reg : work_rd_reg;

    assign weight = tok ? ramp_cur_reg[s1_taddr] : 16'sd0;
    assign goal   = ramp_goal_reg[s1_taddr];
    assign step   = ramp_step_reg[s1_taddr];

    assign offset.x = s1_item_reg.value_x;
    assign offset.y = s1_item_reg.value_y;
    assign offset.z = s1_item_reg.value_z;

    // Scaled offset: full product, arithmetic shift by the fraction, wrap to 16.
    assign prod_x = offset.x * weight;
    assign prod_y = offset.y * weight;
    assign prod_z = offset.z * weight;

    assign applied.x = work_cur.x + prod_x[mtvb_pkg::WEIGHT_FRAC +: 16];
    assign applied.y = work_cur.y + prod_y[mtvb_pkg::WEIGHT_FRAC +: 16];
    assign applied.z = work_cur.z + prod_z[mtvb_pkg::WEIGHT_FRAC +: 16];

    // Ramp step toward goal, clamped at goal.
    assign cur_dec = 17'(weight) - 17'(signed'({2'b00, step}));
    assign cur_inc = 17'(weight) + 17'(signed'({2'b00, step}));

    always_comb begin
        cur_new = weight;
        if (weight > goal) begin
            cur_new = (cur_dec < 17'(goal)) ? goal : cur_dec[15:0];
        end else if (weight < goal) begin
            cur_new = (cur_inc > 17'(goal)) ? goal : cur_inc[15:0];
        end
    end

    always_comb begin
        work_new = work_cur;
        base_new = offset;
        work_we  = 1'b0;
        base_we  = 1'b0;
        cur_we   = 1'b0;
        ramp_set = 1'b0;
        unique case (s1_item_reg.action)
            mtvb_pkg::ACT_LOAD: begin
                base_we  = vok;
                work_we  = vok;
                work_new = offset;
            end
            mtvb_pkg::ACT_SET: begin
                ramp_set = tok;
            end
            mtvb_pkg::ACT_RESTORE: begin
                work_we  = vok;
                work_new = base_cur;
            end
            mtvb_pkg::ACT_ADVANCE: begin
                cur_we = tok;
            end
            mtvb_pkg::ACT_APPLY: begin
                if (vok && weight != 16'sd0) begin
                    work_we  = 1'b1;
                    work_new = applied;
                end
            end
            default: begin
                // read and unused codes: no change
            end
        endcase
    end

    always_comb begin
        result.vertex_x   = vok ? work_new.x : 16'sd0;
        result.vertex_y   = vok ? work_new.y : 16'sd0;
        result.vertex_z   = vok ? work_new.z : 16'sd0;
        result.weight_now = !tok ? 16'sd0 : (cur_we ? cur_new : weight);
    end

    assign fwd_base_hit_next = s1_fire && base_we && (s1_vaddr == rd_addr);
    assign fwd_work_hit_next = s1_fire && work_we && (s1_vaddr == rd_addr);

    // Vertex memories
    always_ff @(posedge aclk) begin
        if (s1_fire && base_we) begin
            base_mem[s1_vaddr] <= base_new;
        end
        if (s1_fire && work_we) begin
            work_mem[s1_vaddr] <= work_new;
        end
        if (accept) begin
            base_rd_reg <= base_mem[rd_addr];
            work_rd_reg <= work_mem[rd_addr];
        end
    end

    // Stage and bypass payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg      <= s_data;
            fwd_base_hit_reg <= fwd_base_hit_next;
            fwd_work_hit_reg <= fwd_work_hit_next;
            fwd_base_reg     <= base_new;
            fwd_work_reg     <= work_new;
        end
        if (s1_fire) begin
            m_data_reg <= result;
        end
    end

    // Control and ramps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < mtvb_pkg::NUM_TARGETS; i++) begin
                ramp_cur_reg[i]  <= '0;
                ramp_goal_reg[i] <= '0;
                ramp_step_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                s1_valid_reg <= accept;
            end
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (s1_fire && cur_we) begin
                ramp_cur_reg[s1_taddr] <= cur_new;
            end
            if (s1_fire && ramp_set) begin
                ramp_goal_reg[s1_taddr] <= s1_item_reg.weight_goal;
                ramp_step_reg[s1_taddr] <= s1_item_reg.weight_step;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
